/* hdl/mips32_instruction_encoder_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the instruction encoder modules.
// Each macro builds one labeled concurrent assertion that is clocked by clk,
// is disabled while rst_n is low, and reports a failure with $error.
// ---------------------------------------------------------------------------
`ifndef MIPS32_INSTRUCTION_ENCODER_ASSERT_SVH
`define MIPS32_INSTRUCTION_ENCODER_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define MIE_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The condition holds in the cycle after the trigger.
`define MIE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/mie_pkg.sv */
// ---------------------------------------------------------------------------
// mie_pkg
// Types and fixed encodings shared by the MIPS32 instruction encoder.
// ---------------------------------------------------------------------------
package mie_pkg;

    // Mnemonic codes as they arrive on the command channel.
    localparam logic [4:0] MODE_ADD  = 5'd0;
    localparam logic [4:0] MODE_ADDU = 5'd1;
    localparam logic [4:0] MODE_SUB  = 5'd2;
    localparam logic [4:0] MODE_AND  = 5'd3;
    localparam logic [4:0] MODE_OR   = 5'd4;
    localparam logic [4:0] MODE_NOR  = 5'd5;
    localparam logic [4:0] MODE_SLT  = 5'd6;
    localparam logic [4:0] MODE_SLL  = 5'd7;
    localparam logic [4:0] MODE_SRL  = 5'd8;
    localparam logic [4:0] MODE_SRA  = 5'd9;
    localparam logic [4:0] MODE_JR   = 5'd10;
    localparam logic [4:0] MODE_MULT = 5'd11;
    localparam logic [4:0] MODE_DIV  = 5'd12;
    localparam logic [4:0] MODE_MFHI = 5'd13;
    localparam logic [4:0] MODE_MFLO = 5'd14;
    localparam logic [4:0] MODE_ADDI = 5'd15;
    localparam logic [4:0] MODE_ANDI = 5'd16;
    localparam logic [4:0] MODE_ORI  = 5'd17;
    localparam logic [4:0] MODE_LUI  = 5'd18;
    localparam logic [4:0] MODE_LW   = 5'd19;
    localparam logic [4:0] MODE_SW   = 5'd20;
    localparam logic [4:0] MODE_BEQ  = 5'd21;
    localparam logic [4:0] MODE_BNE  = 5'd22;
    localparam logic [4:0] MODE_J    = 5'd23;
    localparam logic [4:0] MODE_JAL  = 5'd24;
    localparam logic [4:0] MODE_SUBI = 5'd25;
    localparam logic [4:0] MODE_MOVE = 5'd26;
    localparam logic [4:0] MODE_LI   = 5'd27;
    localparam logic [4:0] MODE_BGE  = 5'd28;
    localparam logic [4:0] MODE_BGT  = 5'd29;
    localparam logic [4:0] MODE_BLE  = 5'd30;
    localparam logic [4:0] MODE_BLT  = 5'd31;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes of the SPECIAL group.
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    // Assembler temporary register used by pseudo-instruction expansion.
    localparam logic [4:0] AT_REG   = 5'd1;
    localparam logic [4:0] ZERO_REG = 5'd0;

    localparam logic [31:0] TEXT_BASE_RESET = 32'h0040_0000;

    // Queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One fully encoded input: one or two machine words.
    typedef struct packed {
        logic [31:0] word0;
        logic [31:0] word1;
        logic        two;
    } mie_entry_t;

    // Front end to queue.
    typedef struct packed {
        logic       valid;
        mie_entry_t entry;
    } mie_push_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic       valid;
        mie_entry_t entry;
    } mie_head_t;

endpackage

/* hdl/mie_if.sv */
// ---------------------------------------------------------------------------
// mie_if
// Valid/ready channels of the instruction encoder: command, result and
// text base configuration.
// ---------------------------------------------------------------------------
interface mie_cmd_if;
    logic               valid;
    logic               ready;
    logic        [4:0]  mode;
    logic        [4:0]  operand_reg_first;
    logic        [4:0]  operand_reg_second;
    logic        [4:0]  operand_reg_third;
    logic signed [31:0] immediate_value;
    logic        [15:0] target_index;
    logic               restart;

    modport source (
        output valid, mode, operand_reg_first, operand_reg_second,
               operand_reg_third, immediate_value, target_index, restart,
        input  ready
    );
    modport sink (
        input  valid, mode, operand_reg_first, operand_reg_second,
               operand_reg_third, immediate_value, target_index, restart,
        output ready
    );
endinterface

interface mie_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] machine_word;
    logic        last_word;

    modport source (output valid, machine_word, last_word, input ready);
    modport sink (input valid, machine_word, last_word, output ready);
endinterface

interface mie_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] text_base;

    modport source (output valid, text_base, input ready);
    modport sink (input valid, text_base, output ready);
endinterface

/* hdl/mie_front.sv */
// ---------------------------------------------------------------------------
// mie_front
// Accepts a tokenized instruction, expands pseudo-instructions and encodes
// one or two machine words into a queue entry. Owns the word counter and
// the text base register.
// ---------------------------------------------------------------------------
module mie_front #(
    parameter int INDEX_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    mie_cmd_if.sink             cmd,
    mie_cfg_if.sink             cfg,
    input  logic                full,
    output mie_pkg::mie_push_t  push
);
    import mie_pkg::*;

    localparam int XW = (INDEX_BITS > 16) ? INDEX_BITS : 16;
    localparam logic [XW-1:0] IDX_MASK = XW'((64'd1 << INDEX_BITS) - 64'd1);

    logic [INDEX_BITS-1:0] counter_reg;
    logic [INDEX_BITS-1:0] counter_next;
    logic [31:0]           text_base_reg;

    logic                  accept;
    logic [INDEX_BITS-1:0] pos;
    logic [INDEX_BITS-1:0] bpos;
    logic [XW-1:0]         tgt_x;
    logic [15:0]           tgt16;
    logic [15:0]           off_here;
    logic [15:0]           off_next;
    logic [31:0]           jaddr;
    logic [15:0]           imm16;
    logic                  li_short;
    logic                  swap;
    logic [4:0]            ra;
    logic [4:0]            rb;
    logic [4:0]            rc;
    mie_entry_t            entry;

    function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [4:0] sh, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    assign cmd.ready = !full;
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && cmd.ready;

    assign ra    = cmd.operand_reg_first;
    assign rb    = cmd.operand_reg_second;
    assign rc    = cmd.operand_reg_third;
    assign imm16 = cmd.immediate_value[15:0];

    // A restart puts this instruction at index zero.
    assign pos  = cmd.restart ? '0 : counter_reg;
    assign bpos = pos + INDEX_BITS'(1);

    assign tgt_x = XW'(cmd.target_index) & IDX_MASK;
    assign tgt16 = tgt_x[15:0];

    // Branch offsets are taken modulo 2^16, so only the low halves matter.
    assign off_here = 16'(tgt_x - XW'(pos) - XW'(1));
    assign off_next = 16'(tgt_x - XW'(bpos) - XW'(1));

    assign jaddr = text_base_reg + 32'({tgt_x, 2'b00});

    // li fits one addi when the upper 17 bits are a sign extension.
    assign li_short = (cmd.immediate_value[31:15] == 17'h0_0000)
                   || (cmd.immediate_value[31:15] == 17'h1_FFFF);

    assign swap = (cmd.mode == MODE_BGT) || (cmd.mode == MODE_BLE);

    always_comb
    begin
        entry.word0 = '0;
        entry.word1 = '0;
        entry.two   = 1'b0;
        case (cmd.mode)
            MODE_ADD:  entry.word0 = enc_r(rb, rc, ra, 5'd0, FN_ADD);
            MODE_ADDU: entry.word0 = enc_r(rb, rc, ra, 5'd0, FN_ADDU);
            MODE_SUB:  entry.word0 = enc_r(rb, rc, ra, 5'd0, FN_SUB);
            MODE_AND:  entry.word0 = enc_r(rb, rc, ra, 5'd0, FN_AND);
            MODE_OR:   entry.word0 = enc_r(rb, rc, ra, 5'd0, FN_OR);
            MODE_NOR:  entry.word0 = enc_r(rb, rc, ra, 5'd0, FN_NOR);
            MODE_SLT:  entry.word0 = enc_r(rb, rc, ra, 5'd0, FN_SLT);
            MODE_SLL:  entry.word0 = enc_r(ZERO_REG, rb, ra, imm16[4:0], FN_SLL);
            MODE_SRL:  entry.word0 = enc_r(ZERO_REG, rb, ra, imm16[4:0], FN_SRL);
            MODE_SRA:  entry.word0 = enc_r(ZERO_REG, rb, ra, imm16[4:0], FN_SRA);
            MODE_JR:   entry.word0 = enc_r(ra, ZERO_REG, ZERO_REG, 5'd0, FN_JR);
            MODE_MULT: entry.word0 = enc_r(ra, rb, ZERO_REG, 5'd0, FN_MULT);
            MODE_DIV:  entry.word0 = enc_r(ra, rb, ZERO_REG, 5'd0, FN_DIV);
            MODE_MFHI: entry.word0 = enc_r(ZERO_REG, ZERO_REG, ra, 5'd0, FN_MFHI);
            MODE_MFLO: entry.word0 = enc_r(ZERO_REG, ZERO_REG, ra, 5'd0, FN_MFLO);
            MODE_ADDI: entry.word0 = enc_i(OP_ADDI, rb, ra, imm16);
            MODE_ANDI: entry.word0 = enc_i(OP_ANDI, rb, ra, imm16);
            MODE_ORI:  entry.word0 = enc_i(OP_ORI, rb, ra, imm16);
            MODE_LUI:  entry.word0 = enc_i(OP_LUI, ZERO_REG, ra, imm16);
            MODE_LW:   entry.word0 = enc_i(OP_LW, rb, ra, imm16);
            MODE_SW:   entry.word0 = enc_i(OP_SW, rb, ra, imm16);
            MODE_BEQ:  entry.word0 = enc_i(OP_BEQ, ra, rb, off_here);
            MODE_BNE:  entry.word0 = enc_i(OP_BNE, ra, rb, off_here);
            MODE_J:    entry.word0 = {OP_J, jaddr[27:2]};
            MODE_JAL:  entry.word0 = {OP_JAL, jaddr[27:2]};
            MODE_SUBI: entry.word0 = enc_i(OP_ADDI, rb, ra, 16'd0 - imm16);
            MODE_MOVE: entry.word0 = enc_r(rb, ZERO_REG, ra, 5'd0, FN_ADD);
            MODE_LI:
            begin
                if (li_short)
                begin
                    entry.word0 = enc_i(OP_ADDI, ZERO_REG, ra, imm16);
                end
                else
                begin
                    entry.word0 = enc_i(OP_LUI, ZERO_REG, AT_REG,
                                        cmd.immediate_value[31:16]);
                    entry.word1 = enc_i(OP_ORI, AT_REG, ra, imm16);
                    entry.two   = 1'b1;
                end
            end
            MODE_BGE, MODE_BGT, MODE_BLE, MODE_BLT:
            begin
                // slt $at, then branch on $at against $zero.
                entry.word0 = swap ? enc_r(rb, ra, AT_REG, 5'd0, FN_SLT)
                                   : enc_r(ra, rb, AT_REG, 5'd0, FN_SLT);
                entry.word1 = enc_i(((cmd.mode == MODE_BGT) || (cmd.mode == MODE_BLT))
                                    ? OP_BNE : OP_BEQ, AT_REG, ZERO_REG, off_next);
                entry.two   = 1'b1;
            end
            default:
            begin
                entry.word0 = '0;
            end
        endcase
    end

    assign counter_next = pos + (entry.two ? INDEX_BITS'(2) : INDEX_BITS'(1));

    assign push = '{valid: accept, entry: entry};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            text_base_reg <= TEXT_BASE_RESET;
        end
        else
        begin
            if (accept)
            begin
                counter_reg <= counter_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                text_base_reg <= cfg.text_base;
            end
        end
    end

endmodule

/* hdl/mie_queue.sv */
// ---------------------------------------------------------------------------
// mie_queue
// Two-entry queue of encoded instructions between the front and back ends.
// ---------------------------------------------------------------------------
`include "mips32_instruction_encoder_assert.svh"

module mie_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  mie_pkg::mie_push_t push,
    output logic               full,
    input  logic               pop,
    output mie_pkg::mie_head_t head
);
    import mie_pkg::*;

    mie_entry_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head   = '{valid: (count_reg != '0), entry: entries_reg[rd_ptr_reg]};
    assign do_pop = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `MIE_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, push.valid && !do_pop, !full, "queue written while full")
    `MIE_ASSERT_NEXT(a_queue_count_up, clk, rst_n, push.valid && !do_pop, count_reg == $past(count_reg) + QCNT_W'(1), "queue count did not follow a write")

endmodule

/* hdl/mie_back.sv */
// ---------------------------------------------------------------------------
// mie_back
// Walks the queue head out through an output register, one machine word per
// cycle while res is ready; a two-word entry pops after its second word.
// ---------------------------------------------------------------------------
`include "mips32_instruction_encoder_assert.svh"

module mie_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mie_pkg::mie_head_t head,
    output logic               pop,
    mie_res_if.source          res
);
    import mie_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        phase_reg;
    logic        phase_next;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic        last_reg;
    logic        last_next;
    logic        load;

    assign load = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                if (head.entry.two && !phase_reg)
                begin
                    // First of a pair: the entry stays at the head.
                    word_next  = head.entry.word0;
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    word_next  = phase_reg ? head.entry.word1 : head.entry.word0;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.machine_word = word_reg;
    assign res.last_word    = last_reg;

    `MIE_ASSERT_SAME(a_back_pair_pending, clk, rst_n, out_valid_reg && !last_reg, phase_reg, "first word shown without its pair pending")
    `MIE_ASSERT_SAME(a_back_phase_head, clk, rst_n, phase_reg, head.valid && head.entry.two, "second word pending without a two-word head")

endmodule

/* hdl/mips32_instruction_encoder.sv */
// ---------------------------------------------------------------------------
// mips32_instruction_encoder
// Encodes tokenized MIPS32 instructions, expanding pseudo-instructions, into
// a stream of 32-bit machine words.
// ---------------------------------------------------------------------------
// Usage:
//   cmd takes one tokenized instruction per transfer. res returns its machine
//   words in program order; last_word marks the final word of each
//   instruction. li with a wide value and bge/bgt/ble/blt give two words,
//   everything else gives one.
//   cfg writes the text base used for j and jal targets. Write it only while
//   no instruction is in flight; it is always ready.
// Data path and throughput:
//   A word passes through a queue entry and then the output register before
//   it appears on res. While res is ready, the back end emits one word per
//   cycle, so one-word instructions flow at one per cycle and a two-word
//   instruction gives its words one after the other; that output register is
//   the rate limit.
// Reset:
//   rst_n clears the word counter, empties the queue and the output register
//   and sets the text base to 0x0040_0000.
// Stalls:
//   When res is stalled the word holds in the output register, the queue of
//   two entries fills, and then cmd.ready drops until words drain.
// ---------------------------------------------------------------------------
module mips32_instruction_encoder #(
    parameter int INDEX_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mie_cmd_if.sink   cmd,
    mie_cfg_if.sink   cfg,
    mie_res_if.source res
);
    import mie_pkg::*;

    // Front end: decode, expand, encode; one instruction per cycle unless full.
    mie_push_t push;
    logic      full;
    // Back end: one word per cycle from the queue head while res is ready.
    mie_head_t head;
    logic      pop;

    mie_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .full  (full),
        .push  (push)
    );

    // The queue lets the front keep accepting while a word waits on res.
    mie_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    mie_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule
